@@ rtl/frpx_pkg.sv @@
package frpx_pkg;

    // Fixed point format of every sample and result
    localparam int SAMPLE_W            = 32;
    localparam int FRACTION_BITS       = 16;
    localparam int GAMMA_TABLE_ENTRIES = 256;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam logic [SAMPLE_W-1:0] ONE_FX  = SAMPLE_W'(64'd1 << FRACTION_BITS);
    localparam sample_t             ONE_S   = sample_t'(ONE_FX);
    localparam sample_t             ZERO_S  = '0;

    // Linear segment threshold, round(0.0031308 * one)
    localparam longint unsigned LIN_THR =
        ((64'd31308 << FRACTION_BITS) + 64'd5000000) / 64'd10000000;
    localparam sample_t         LIN_THR_S = sample_t'(LIN_THR);
    localparam int              LIN_THR_W = $clog2(LIN_THR + 1);

    // (v * 1292 + 50) / 100 as a reciprocal multiply
    localparam int LIN_N_W   = $clog2(LIN_THR * 1292 + 51);
    localparam int LIN_SHIFT = LIN_N_W + 7;
    localparam longint unsigned LIN_RECIP = ((64'd1 << LIN_SHIFT) + 64'd99) / 64'd100;
    localparam int LIN_RECIP_W = $clog2(LIN_RECIP + 1);
    localparam int LIN_P_W     = LIN_N_W + LIN_RECIP_W;

    // Gamma table
    localparam int GAMMA_W = FRACTION_BITS + 1;
    localparam int IDX_W   = $clog2(GAMMA_TABLE_ENTRIES + 1);

    // Divisors used only while the table is built at elaboration
    localparam logic [63:0] GAMMA_X_DEN = 64'(GAMMA_TABLE_ENTRIES);
    localparam logic [63:0] GAMMA_E_DEN = 64'd1000 << 20;

    typedef logic [GAMMA_W-1:0] gamma_tab_t [0:GAMMA_TABLE_ENTRIES];

    typedef enum logic [1:0] {
        MODE_COLOR  = 2'd0,
        MODE_DEPTH  = 2'd1,
        MODE_NORMAL = 2'd2
    } channel_mode_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHANNEL_MODE = 2'd0,
        CFG_SRGB_ENABLE  = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        channel_mode_t channel_mode;
        logic          srgb_enable;
    } cfg_t;

    typedef struct packed {
        sample_t chan_a;
        sample_t chan_b;
        sample_t chan_c;
        sample_t chan_d;
    } pixel_in_t;

    typedef struct packed {
        sample_t red;
        sample_t green;
        sample_t blue;
        sample_t alpha;
    } pixel_out_t;

    // Elaboration-time helpers for the gamma table
    function automatic logic [63:0] isqrt(input logic [63:0] a);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = a;
        res  = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] icbrt(input logic [63:0] a);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        lo = '0;
        hi = 64'd1 << 21;
        while (hi - lo > 64'd1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid * mid <= a)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // 1.055 * x^(5/12) - 0.055, x = i / entries, clamped to [0, one]
    function automatic gamma_tab_t build_gamma_tab();
        gamma_tab_t          tab;
        logic [63:0]         x;
        logic [63:0]         r4;
        logic [63:0]         r6;
        logic [63:0]         y;
        longint              num;
        logic [63:0]         e;
        for (int i = 0; i <= GAMMA_TABLE_ENTRIES; i++) begin
            x   = (64'(i) << 20) / GAMMA_X_DEN;
            r4  = isqrt(isqrt(x << 20) << 20);
            r6  = isqrt(icbrt(x << 40) << 20);
            y   = (r4 * r6 + (64'd1 << 19)) >> 20;
            num = longint'(64'd1055 * y) - longint'(64'd55 << 20);
            e   = '0;
            if (num > 0) begin
                e = ((64'(num) << FRACTION_BITS) + (64'd500 << 20)) / GAMMA_E_DEN;
                if (e > 64'(ONE_FX))
                    e = 64'(ONE_FX);
            end
            tab[i] = GAMMA_W'(e);
        end
        return tab;
    endfunction

    localparam gamma_tab_t GAMMA_TAB = build_gamma_tab();

endpackage

@@ rtl/frpx_cfg_regs.sv @@
module frpx_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [frpx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frpx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output frpx_pkg::cfg_t                  cfg
);
    import frpx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_CHANNEL_MODE: cfg_next.channel_mode = channel_mode_t'(cfg_wdata[1:0]);
                CFG_SRGB_ENABLE:  cfg_next.srgb_enable  = cfg_wdata[0];
                default:          cfg_next = cfg_reg;  // unmapped index: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{channel_mode: MODE_COLOR, srgb_enable: 1'b0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/frpx_srgb_lane.sv @@
module frpx_srgb_lane (
    input  frpx_pkg::sample_t v,
    output frpx_pkg::sample_t y
);
    import frpx_pkg::*;

    localparam int P_W    = FRACTION_BITS + IDX_W;
    localparam int D_W    = GAMMA_W + 1;
    localparam int PROD_W = D_W + FRACTION_BITS + 1;

    logic [FRACTION_BITS:0]          vm;
    logic [P_W-1:0]                  p;
    logic [IDX_W-1:0]                idx_raw;
    logic [IDX_W-1:0]                idx;
    logic [IDX_W-1:0]                nxt;
    logic [FRACTION_BITS-1:0]        frac;
    logic [GAMMA_W-1:0]              lo_val;
    logic [GAMMA_W-1:0]              hi_val;
    logic signed [D_W-1:0]           diff;
    logic signed [PROD_W-1:0]        prod;
    logic signed [PROD_W-1:0]        step;
    logic signed [D_W:0]             interp;
    logic [LIN_N_W-1:0]              lin_n;
    logic [LIN_P_W-1:0]              lin_p;
    sample_t                         lin_y;

    // Table interpolation, valid for 0 < v <= one
    always_comb begin
        vm      = v[FRACTION_BITS:0];
        p       = P_W'(vm) * P_W'(GAMMA_TABLE_ENTRIES);
        idx_raw = p[P_W-1:FRACTION_BITS];
        frac    = p[FRACTION_BITS-1:0];
        idx     = (idx_raw > IDX_W'(GAMMA_TABLE_ENTRIES)) ?
                  IDX_W'(GAMMA_TABLE_ENTRIES) : idx_raw;
        nxt     = (idx < IDX_W'(GAMMA_TABLE_ENTRIES)) ? idx + 1'b1 : idx;
        lo_val  = GAMMA_TAB[idx];
        hi_val  = GAMMA_TAB[nxt];
        // lo*(one-f) + hi*f == lo*one + (hi-lo)*f, so only one product
        diff    = signed'({1'b0, hi_val}) - signed'({1'b0, lo_val});
        prod    = PROD_W'(diff) * signed'(PROD_W'({1'b0, frac}));
        step    = (prod + signed'(PROD_W'(ONE_FX >> 1))) >>> FRACTION_BITS;
        interp  = signed'((D_W + 1)'({1'b0, lo_val})) + (D_W + 1)'(step);
    end

    // Linear segment: (v * 1292 + 50) / 100
    always_comb begin
        lin_n = LIN_N_W'(v[LIN_THR_W-1:0]) * LIN_N_W'(1292) + LIN_N_W'(50);
        lin_p = LIN_P_W'(lin_n) * LIN_P_W'(LIN_RECIP);
        lin_y = sample_t'(lin_p >> LIN_SHIFT);
    end

    always_comb begin
        priority if (v <= ZERO_S) begin
            y = ZERO_S;
        end else if (v <= LIN_THR_S) begin
            y = lin_y;
        end else if (v > ONE_S) begin
            y = ONE_S;
        end else begin
            y = sample_t'(interp);
        end
    end

endmodule

@@ rtl/frpx_pixel_map.sv @@
module frpx_pixel_map (
    input  frpx_pkg::cfg_t       cfg,
    input  frpx_pkg::pixel_in_t  pix_in,
    output frpx_pkg::pixel_out_t pix_out
);
    import frpx_pkg::*;

    pixel_out_t enc;

    frpx_srgb_lane u_lane_a (.v(pix_in.chan_a), .y(enc.red));
    frpx_srgb_lane u_lane_b (.v(pix_in.chan_b), .y(enc.green));
    frpx_srgb_lane u_lane_c (.v(pix_in.chan_c), .y(enc.blue));
    frpx_srgb_lane u_lane_d (.v(pix_in.chan_d), .y(enc.alpha));

    always_comb begin
        unique case (cfg.channel_mode)
            MODE_COLOR: begin
                if (cfg.srgb_enable) begin
                    pix_out = enc;
                end else begin
                    pix_out = '{red:   pix_in.chan_a, green: pix_in.chan_b,
                                blue:  pix_in.chan_c, alpha: pix_in.chan_d};
                end
            end
            MODE_DEPTH: begin
                pix_out = '{red:  pix_in.chan_a, green: pix_in.chan_a,
                            blue: pix_in.chan_a, alpha: ONE_S};
            end
            default: begin
                // normal/albedo, and the unused code behaves the same
                pix_out = '{red:  pix_in.chan_a, green: pix_in.chan_b,
                            blue: pix_in.chan_c, alpha: ONE_S};
            end
        endcase
    end

endmodule

@@ rtl/framebuffer_pixel_to_rgba_srgb.sv @@
// Render pixel to RGBA converter with optional sRGB gamma encoding.
// Input channel s_*: one render pixel (chan_a..chan_d, signed Q16.16) per
// transfer. Output channel m_*: one RGBA pixel (red, green, blue, alpha,
// signed Q16.16) per input transfer, in order.
// Config port cfg_*: channel_mode (index 0) and srgb_enable (index 1),
// written with no read-back; write only while the block is idle.
// A pixel taken on s_* is presented on m_* after passing two registers:
// the input register, then the result register.
// Throughput: one pixel per clock while m_ready is high. The whole conversion,
// including the gamma table lookup and its single interpolation multiply,
// sits between the input register and the result register.
// Reset (aresetn low, synchronous): both pipeline stages empty, config back
// to color mode with sRGB off. The gamma table is a constant, so there is
// no start-up sweep.
// Receiver stall: the result register holds its pixel; the input register
// still takes one more pixel, after which s_ready drops until m_ready.
module framebuffer_pixel_to_rgba_srgb (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  frpx_pkg::pixel_in_t              s_pixel,
    output logic                             m_valid,
    input  logic                             m_ready,
    output frpx_pkg::pixel_out_t             m_pixel,
    input  logic                             cfg_wr_en,
    input  logic [frpx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [frpx_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import frpx_pkg::*;

    cfg_t       cfg;
    pixel_out_t mapped;

    // stage 1: input register
    logic       in_valid_reg;
    pixel_in_t  in_pix_reg;
    // stage 2: result register
    logic       out_valid_reg;
    pixel_out_t out_pix_reg;

    logic       out_adv;   // result register may load this cycle
    logic       in_adv;    // input register may load this cycle

    frpx_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    frpx_pixel_map u_map (
        .cfg     (cfg),
        .pix_in  (in_pix_reg),
        .pix_out (mapped)
    );

    // Result register frees up when empty or when its pixel leaves now.
    assign out_adv = !out_valid_reg || m_ready;
    assign in_adv  = !in_valid_reg || out_adv;
    assign s_ready = in_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_adv)
                in_valid_reg <= s_valid;
            if (out_adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (in_adv && s_valid)
            in_pix_reg <= s_pixel;
        if (out_adv && in_valid_reg)
            out_pix_reg <= mapped;
    end

    assign m_valid = out_valid_reg;
    assign m_pixel = out_pix_reg;

`ifndef NO_ASSERTIONS
    // both stages full and output stalled: no room for another pixel
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input accepted with both stages full and output stalled");

    // an accepted pixel lands in the input register
    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted pixel lost at input register");

    // a pixel in stage 1 moves on whenever the result register has room
    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_adv) |=> m_valid)
        else $error("pixel lost between input and result registers");
`endif

endmodule

@@ sim/rgba_pixel_checker.sv @@
module rgba_pixel_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  frpx_pkg::pixel_in_t               s_pixel,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  frpx_pkg::pixel_out_t              m_pixel,
    input  logic                              cfg_wr_en,
    input  logic [frpx_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [frpx_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                                n_fail,
    output int                                n_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import frpx_pkg::*;

    localparam longint unsigned ONE_U = 64'd1 << FRACTION_BITS;
    // top of the linear segment, round(0.0031308 * one)
    localparam longint KNEE = ((longint'(31308) << FRACTION_BITS) + 5000000) / 10000000;

    longint unsigned gamma_lut [0:GAMMA_TABLE_ENTRIES];
    channel_mode_t   mode;
    logic            srgb_on;
    pixel_out_t      rgba_due [$];

    function automatic longint unsigned root2(input longint unsigned a);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 32;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid <= a)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic longint unsigned root3(input longint unsigned a);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd1 << 21;
        while (hi - lo > 1) begin
            mid = (lo + hi) >> 1;
            if (mid * mid * mid <= a)
                lo = mid;
            else
                hi = mid;
        end
        return lo;
    endfunction

    // 1.055 * x^(5/12) - 0.055 in integer steps, x^(1/4) * x^(1/6) in Q20
    initial begin
        longint unsigned x;
        longint unsigned q4;
        longint unsigned q6;
        longint unsigned y;
        longint unsigned e;
        longint          num;
        for (int i = 0; i <= GAMMA_TABLE_ENTRIES; i++) begin
            x   = (64'(i) << 20) / GAMMA_TABLE_ENTRIES;
            q4  = root2(root2(x << 20) << 20);
            q6  = root2(root3(x << 40) << 20);
            y   = (q4 * q6 + (64'd1 << 19)) >> 20;
            num = longint'(1055 * y) - longint'(55 << 20);
            e   = 0;
            if (num > 0) begin
                e = ((num << FRACTION_BITS) + (500 << 20)) / (1000 << 20);
                if (e > ONE_U)
                    e = ONE_U;
            end
            gamma_lut[i] = e;
        end
    end

    function automatic sample_t srgb_curve(input sample_t v);
        longint unsigned pos;
        longint unsigned idx;
        longint unsigned frac;
        longint unsigned nxt;
        longint unsigned acc;
        if (v <= 0)
            return ZERO_S;
        if (v <= KNEE)
            return sample_t'((longint'(v) * 1292 + 50) / 100);
        if (v > ONE_S)
            return ONE_S;
        pos  = longint'(v) * GAMMA_TABLE_ENTRIES;
        idx  = pos >> FRACTION_BITS;
        frac = pos & (ONE_U - 1);
        if (idx > GAMMA_TABLE_ENTRIES)
            idx = GAMMA_TABLE_ENTRIES;
        nxt = (idx < GAMMA_TABLE_ENTRIES) ? idx + 1 : idx;
        acc = gamma_lut[idx] * (ONE_U - frac) + gamma_lut[nxt] * frac + (ONE_U >> 1);
        return sample_t'(acc >> FRACTION_BITS);
    endfunction

    function automatic pixel_out_t rgba_of(input pixel_in_t px);
        pixel_out_t q;
        case (mode)
            MODE_COLOR: begin
                q.red   = srgb_on ? srgb_curve(px.chan_a) : px.chan_a;
                q.green = srgb_on ? srgb_curve(px.chan_b) : px.chan_b;
                q.blue  = srgb_on ? srgb_curve(px.chan_c) : px.chan_c;
                q.alpha = srgb_on ? srgb_curve(px.chan_d) : px.chan_d;
            end
            MODE_DEPTH: begin
                q.red   = px.chan_a;
                q.green = px.chan_a;
                q.blue  = px.chan_a;
                q.alpha = ONE_S;
            end
            // normal/albedo, unused code 3 behaves the same
            default: begin
                q.red   = px.chan_a;
                q.green = px.chan_b;
                q.blue  = px.chan_c;
                q.alpha = ONE_S;
            end
        endcase
        return q;
    endfunction

    task automatic note_fault(input string msg);
        $display("%0t ns rgba check: %s", $time, msg);
        n_fail++;
    endtask

    task automatic check_field(input string name, input sample_t got, input sample_t want);
        if (got !== want)
            note_fault($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge aclk) begin
        pixel_out_t want;
        if (!aresetn) begin
            mode    = MODE_COLOR;
            srgb_on = 1'b0;
            rgba_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (rgba_due.size() == 0) begin
                    note_fault($sformatf("unexpected pixel %h", m_pixel));
                end else begin
                    want = rgba_due.pop_front();
                    check_field("red",   m_pixel.red,   want.red);
                    check_field("green", m_pixel.green, want.green);
                    check_field("blue",  m_pixel.blue,  want.blue);
                    check_field("alpha", m_pixel.alpha, want.alpha);
                end
            end
            if (s_valid && s_ready)
                rgba_due = {rgba_due, rgba_of(s_pixel)};
            if (cfg_wr_en) begin
                if (cfg_index == CFG_CHANNEL_MODE)
                    mode = channel_mode_t'(cfg_wdata);
                else if (cfg_index == CFG_SRGB_ENABLE)
                    srgb_on = cfg_wdata[0];
            end
        end
        n_pending <= rgba_due.size();
    end

endmodule

@@ sim/tb.sv @@
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import frpx_pkg::*;

    localparam int HALF_PERIOD = 4;

    // Codes with no name in the package: the spare channel mode and the two
    // register indexes that decode to nothing.
    localparam logic [1:0]             MODE_SPARE   = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam logic [CFG_DATA_W-1:0]  SRGB_OFF     = 2'd0;
    localparam logic [CFG_DATA_W-1:0]  SRGB_ON      = 2'd1;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    pixel_in_t               s_pixel   = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    pixel_out_t              m_pixel;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

    int n_fail;
    int n_pending;

    // Chance, in percent, that the sender skips a cycle / the receiver stalls
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    // Cycles left in a forced receiver hold-off
    int sink_hold      = 0;

    always #HALF_PERIOD aclk = ~aclk;

    framebuffer_pixel_to_rgba_srgb dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pixel   (m_pixel),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rgba_pixel_checker rgba_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pixel   (m_pixel),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .n_fail    (n_fail),
        .n_pending (n_pending)
    );

    // Receiver. A hold-off, once armed, is counted down here and keeps
    // m_ready low throughout; otherwise ready follows the stall rate.
    always @(posedge aclk) begin
        if (sink_hold != 0) begin
            m_ready   <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Register write, one cycle of enable. The extra edge afterwards keeps
    // back-to-back writes from raising and lowering the enable in one step.
    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Offers one pixel and returns at the edge of its transfer, leaving valid
    // high: the next call either replaces the payload in the same step or
    // drops valid for a gap, so valid gets one update per step at most.
    task automatic send_pixel(input pixel_in_t px);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Stop offering, let every expected pixel come back, then let the two
    // pipeline stages settle before touching the registers again.
    task automatic drain_wait();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (n_pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Sample mix aimed at the sRGB curve: the linear segment around its
    // knee, the table range, the clamp at one, negatives and full-width noise.
    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0, 1:    return sample_t'($urandom());
            2:       return sample_t'(int'($urandom_range(600)) - 300);
            3, 4, 5: return sample_t'($urandom_range(65536));
            6:       return sample_t'(int'($urandom_range(20)) + 65526);
            7:       return sample_t'(-int'($urandom_range(65536)));
            8: begin
                case ($urandom_range(3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return ZERO_S;
                    default: return -32'sd1;
                endcase
            end
            default: return sample_t'($urandom_range(255) << $urandom_range(8));
        endcase
    endfunction

    task automatic run_phase(input logic [1:0] mode, input logic [CFG_DATA_W-1:0] srgb,
                             input int src_idle, input int sink_stall, input int n_items);
        pixel_in_t px;
        set_reg(CFG_CHANNEL_MODE, mode);
        set_reg(CFG_SRGB_ENABLE, srgb);
        src_idle_pct   = src_idle;
        sink_stall_pct = sink_stall;
        repeat (n_items) begin
            px = '{pick_sample(), pick_sample(), pick_sample(), pick_sample()};
            send_pixel(px);
        end
        drain_wait();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // colour with sRGB: zero, negatives, the linear knee either side,
        // exactly one and just above, table boundaries, full-scale extremes
        set_reg(CFG_CHANNEL_MODE, MODE_COLOR);
        set_reg(CFG_SRGB_ENABLE, SRGB_ON);
        send_pixel('{32'sd0, -32'sd1, 32'sd1, 32'sh8000_0000});
        send_pixel('{32'sd205, 32'sd206, 32'sd65536, 32'sd65537});
        send_pixel('{32'sh7FFF_FFFF, 32'sd32768, 32'sd256, 32'sd65280});
        send_pixel('{32'sd65535, 32'sd255, 32'sd257, 32'sd100});
        send_pixel('{-32'sd65536, 32'sd13107, 32'sd50000, 32'sd65279});
        drain_wait();

        // plain colour copy of the extremes
        set_reg(CFG_SRGB_ENABLE, SRGB_OFF);
        send_pixel('{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd65536});
        drain_wait();

        // depth: sRGB left on must have no effect, b..d are ignored
        set_reg(CFG_CHANNEL_MODE, MODE_DEPTH);
        set_reg(CFG_SRGB_ENABLE, SRGB_ON);
        send_pixel('{32'sd12345, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1});
        send_pixel('{32'sh8000_0000, 32'sd1, 32'sd2, 32'sd3});
        drain_wait();

        // normal/albedo, then the spare mode code which behaves the same
        set_reg(CFG_CHANNEL_MODE, MODE_NORMAL);
        send_pixel('{-32'sd65536, 32'sd131072, 32'sh8000_0000, 32'sh7FFF_FFFF});
        drain_wait();
        set_reg(CFG_CHANNEL_MODE, MODE_SPARE);
        send_pixel('{32'sd1, 32'sd2, 32'sd3, 32'sd4});
        send_pixel('{32'sh7FFF_FFFF, -32'sd7, 32'sd40000, 32'sh8000_0000});
        drain_wait();

        // writes to undecoded indexes must change nothing
        set_reg(CFG_SPARE_LO, MODE_COLOR);
        set_reg(CFG_SPARE_HI, SRGB_OFF);
        send_pixel('{32'sd30000, 32'sd500, 32'sd65536, -32'sd2});
        drain_wait();

        // only bit 0 of the sRGB write counts
        set_reg(CFG_CHANNEL_MODE, MODE_COLOR);
        set_reg(CFG_SRGB_ENABLE, 2'b10);
        send_pixel('{32'sd30000, 32'sd500, 32'sd1000, 32'sd60000});
        drain_wait();
        set_reg(CFG_SRGB_ENABLE, 2'b11);
        send_pixel('{32'sd30000, 32'sd500, 32'sd1000, 32'sd60000});
        drain_wait();

        // ---- random part: every mode, each idling pattern ----
        run_phase(MODE_COLOR,  SRGB_ON,   0,  0, 200);
        run_phase(MODE_COLOR,  SRGB_ON,  79,  0, 200);
        run_phase(MODE_COLOR,  SRGB_ON,   0, 79, 200);
        run_phase(MODE_COLOR,  SRGB_OFF, 29, 29, 200);
        run_phase(MODE_DEPTH,  SRGB_ON,  79,  0, 200);
        run_phase(MODE_NORMAL, SRGB_OFF,  0, 79, 200);
        run_phase(MODE_SPARE,  SRGB_ON,  29, 29, 200);
        run_phase(MODE_COLOR,  SRGB_ON,  29, 29, 200);

        // ---- back-pressure: receiver held off while the sender keeps
        // offering, so both stages fill and s_ready drops ----
        set_reg(CFG_CHANNEL_MODE, MODE_COLOR);
        set_reg(CFG_SRGB_ENABLE, SRGB_ON);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        sink_hold     <= 300;
        repeat (40)
            send_pixel('{pick_sample(), pick_sample(), pick_sample(), pick_sample()});
        drain_wait();

        if (n_fail == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/frpx_pkg.sv
rtl/frpx_cfg_regs.sv
rtl/frpx_srgb_lane.sv
rtl/frpx_pixel_map.sv
rtl/framebuffer_pixel_to_rgba_srgb.sv
sim/rgba_pixel_checker.sv
sim/tb.sv
